// File: hw/rtl/gpr_pkg.sv
// -----------------------------------------------------------------------------
// gpr_pkg - shared types and font ROM for the glyph renderer
// Transaction payload structs, cell geometry and the 8x8 font lookup.
// -----------------------------------------------------------------------------
package gpr_pkg;

   localparam int GLYPH_COUNT = 95;
   localparam logic [7:0] FIRST_CODE = 8'd32;
   localparam int STORED_COLUMNS = 5;

   typedef struct packed {
      logic [7:0]  char_code;
      logic [15:0] fore_color;
      logic [15:0] back_color;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic [2:0]  pixel_row;
      logic [2:0]  pixel_column;
      logic        last_pixel;
   } rsp_type;

   // Element [4 - c] holds column c; bit r of a column is row r.
   typedef logic [STORED_COLUMNS-1:0][7:0] glyph_type;

   // Glyph n belongs to code FIRST_CODE + n; glyphs past the stored font are blank.
   function automatic glyph_type font_lookup(input logic [7:0] glyph);
      glyph_type r;
      case (glyph)
         8'd0: r = 40'h00_00_00_00_00;
         8'd1: r = 40'h00_00_5F_00_00;
         8'd2: r = 40'h00_07_00_07_00;
         8'd3: r = 40'h14_7F_14_7F_14;
         8'd4: r = 40'h24_2A_7F_2A_12;
         8'd5: r = 40'h23_13_08_64_62;
         8'd6: r = 40'h36_49_55_22_50;
         8'd7: r = 40'h00_05_03_00_00;
         8'd8: r = 40'h00_1C_22_41_00;
         8'd9: r = 40'h00_41_22_1C_00;
         8'd10: r = 40'h14_08_3E_08_14;
         8'd11: r = 40'h08_08_3E_08_08;
         8'd12: r = 40'h00_50_30_00_00;
         8'd13: r = 40'h08_08_08_08_08;
         8'd14: r = 40'h00_60_60_00_00;
         8'd15: r = 40'h20_10_08_04_02;
         8'd16: r = 40'h3E_51_49_45_3E;
         8'd17: r = 40'h00_42_7F_40_00;
         8'd18: r = 40'h42_61_51_49_46;
         8'd19: r = 40'h21_41_45_4B_31;
         8'd20: r = 40'h18_14_12_7F_10;
         8'd21: r = 40'h27_45_45_45_39;
         8'd22: r = 40'h3C_4A_49_49_30;
         8'd23: r = 40'h01_71_09_05_03;
         8'd24: r = 40'h36_49_49_49_36;
         8'd25: r = 40'h06_49_49_29_1E;
         8'd26: r = 40'h00_36_36_00_00;
         8'd27: r = 40'h00_56_36_00_00;
         8'd28: r = 40'h08_14_22_41_00;
         8'd29: r = 40'h14_14_14_14_14;
         8'd30: r = 40'h00_41_22_14_08;
         8'd31: r = 40'h02_01_51_09_06;
         8'd32: r = 40'h32_49_79_41_3E;
         8'd33: r = 40'h7E_11_11_11_7E;
         8'd34: r = 40'h7F_49_49_49_36;
         8'd35: r = 40'h3E_41_41_41_22;
         8'd36: r = 40'h7F_41_41_22_1C;
         8'd37: r = 40'h7F_49_49_49_41;
         8'd38: r = 40'h7F_09_09_09_01;
         8'd39: r = 40'h3E_41_49_49_7A;
         8'd40: r = 40'h7F_08_08_08_7F;
         8'd41: r = 40'h00_41_7F_41_00;
         8'd42: r = 40'h20_40_41_3F_01;
         8'd43: r = 40'h7F_08_14_22_41;
         8'd44: r = 40'h7F_40_40_40_40;
         8'd45: r = 40'h7F_02_0C_02_7F;
         8'd46: r = 40'h7F_04_08_10_7F;
         8'd47: r = 40'h3E_41_41_41_3E;
         8'd48: r = 40'h7F_09_09_09_06;
         8'd49: r = 40'h3E_41_51_21_5E;
         8'd50: r = 40'h7F_09_19_29_46;
         8'd51: r = 40'h46_49_49_49_31;
         8'd52: r = 40'h01_01_7F_01_01;
         8'd53: r = 40'h3F_40_40_40_3F;
         8'd54: r = 40'h1F_20_40_20_1F;
         8'd55: r = 40'h3F_40_38_40_3F;
         8'd56: r = 40'h63_14_08_14_63;
         8'd57: r = 40'h07_08_70_08_07;
         8'd58: r = 40'h61_51_49_45_43;
         8'd59: r = 40'h00_7F_41_41_00;
         8'd60: r = 40'h02_04_08_10_20;
         8'd61: r = 40'h00_41_41_7F_00;
         8'd62: r = 40'h04_02_01_02_04;
         8'd63: r = 40'h40_40_40_40_40;
         8'd64: r = 40'h00_01_02_04_00;
         8'd65: r = 40'h20_54_54_54_78;
         8'd66: r = 40'h7F_48_44_44_38;
         8'd67: r = 40'h38_44_44_44_20;
         8'd68: r = 40'h38_44_44_48_7F;
         8'd69: r = 40'h38_54_54_54_18;
         8'd70: r = 40'h08_7E_09_01_02;
         8'd71: r = 40'h0C_52_52_52_3E;
         8'd72: r = 40'h7F_08_04_04_78;
         8'd73: r = 40'h00_44_7D_40_00;
         8'd74: r = 40'h20_40_44_3D_00;
         8'd75: r = 40'h7F_10_28_44_00;
         8'd76: r = 40'h00_41_7F_40_00;
         8'd77: r = 40'h7C_04_18_04_78;
         8'd78: r = 40'h7C_08_04_04_78;
         8'd79: r = 40'h38_44_44_44_38;
         8'd80: r = 40'h7C_14_14_14_08;
         8'd81: r = 40'h08_14_14_18_7C;
         8'd82: r = 40'h7C_08_04_04_08;
         8'd83: r = 40'h48_54_54_54_20;
         8'd84: r = 40'h04_3F_44_40_20;
         8'd85: r = 40'h3C_40_40_20_7C;
         8'd86: r = 40'h1C_20_40_20_1C;
         8'd87: r = 40'h3C_40_30_40_3C;
         8'd88: r = 40'h44_28_10_28_44;
         8'd89: r = 40'h0C_50_50_50_3C;
         8'd90: r = 40'h44_64_54_4C_44;
         8'd91: r = 40'h00_08_36_41_00;
         8'd92: r = 40'h00_00_7F_00_00;
         8'd93: r = 40'h00_41_36_08_00;
         8'd94: r = 40'h10_08_18_10_08;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/glyph_to_pixel_renderer_unit.sv
// -----------------------------------------------------------------------------
// glyph_to_pixel_renderer_unit - 8x8 text-mode character generator
// Looks up a character in the font ROM and streams its 64 pixels in raster
// order, rows outer and columns inner, one RGB565 pixel per cycle.
// -----------------------------------------------------------------------------
//   channel   handshake               payload
//   ------------------------------------------------------
//   request   start / busy            req_item  (req_type)
//   response  rsp_strobe, one cycle   rsp_item  (rsp_type)
//
// A drawable character gives 64 response transactions back to back; the
// first is registered through active_ff and then rsp_strobe after acceptance.
// busy drops in the cycle that computes the last pixel, so characters stream
// with no gap. A code that is not drawn is accepted and gives nothing.
// Reset clears the counter and the strobe. The receiver cannot stall the
// response channel.
// -----------------------------------------------------------------------------
module glyph_to_pixel_renderer_unit
   import gpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic        active_ff, active_in;
   logic [5:0]  pix_ff, pix_in;
   glyph_type   glyph_ff, glyph_in;
   logic [15:0] fore_ff, fore_in;
   logic [15:0] back_ff, back_in;
   logic        strobe_ff, strobe_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        drawn;
   logic [7:0]  glyph_idx;
   logic [2:0]  cur_row;
   logic [2:0]  cur_col;
   logic [2:0]  col_sel;
   logic        pix_on;

   assign busy      = active_ff & (pix_ff != 6'd63);
   assign accept    = start & ~busy;
   assign glyph_idx = req_item.char_code - FIRST_CODE;
   assign drawn     = (req_item.char_code >= FIRST_CODE)
                      && (9'(glyph_idx) < 9'(GLYPH_COUNT));

   always_comb begin
      active_in = active_ff;
      pix_in    = pix_ff;
      glyph_in  = glyph_ff;
      fore_in   = fore_ff;
      back_in   = back_ff;
      if (active_ff) begin
         pix_in = pix_ff + 6'd1;
         if (pix_ff == 6'd63) begin
            active_in = 1'b0;
         end
      end
      // a new transaction overrides the wrap of the finishing one
      if (accept && drawn) begin
         active_in = 1'b1;
         pix_in    = '0;
         glyph_in  = font_lookup(glyph_idx);
         fore_in   = req_item.fore_color;
         back_in   = req_item.back_color;
      end
   end

   assign cur_row = pix_ff[5:3];
   assign cur_col = pix_ff[2:0];
   assign col_sel = 3'd4 - cur_col;

   always_comb begin
      pix_on = 1'b0;
      if (cur_col < 3'(STORED_COLUMNS)) begin
         pix_on = glyph_ff[col_sel][cur_row];
      end
      strobe_in           = active_ff;
      rsp_in.pixel_color  = pix_on ? fore_ff : back_ff;
      rsp_in.pixel_row    = cur_row;
      rsp_in.pixel_column = cur_col;
      rsp_in.last_pixel   = (pix_ff == 6'd63);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pix_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         pix_ff    <= pix_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      fore_ff  <= fore_in;
      back_ff  <= back_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: bench/glyph_to_pixel_renderer_unit_tb.sv
// -----------------------------------------------------------------------------
// glyph_to_pixel_renderer_unit_tb - self-checking bench for the glyph renderer
// Drives character transactions (a short directed table, then random codes and
// colors), predicts the 64-pixel raster of each drawable code from a local
// font copy and compares every pixel transaction field by field, in order.
// -----------------------------------------------------------------------------
module glyph_to_pixel_renderer_unit_tb
   import gpr_pkg::*;
();

   localparam int STORED_GLYPHS = 95;
   localparam int CELL_SIZE = 8;
   localparam int RANDOM_CHARS = 500;
   localparam int DRAIN_CYCLES = 80;

   // Column bytes 0..4 of each stored glyph, code 32 upward; bit r is row r.
   localparam logic [0:STORED_GLYPHS-1][0:STORED_COLUMNS-1][7:0] FONT_COLUMNS = {
      40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
      40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
      40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
      40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
      40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
      40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
      40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
      40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
      40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
      40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
      40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
      40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
      40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
      40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
      40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
      40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
      40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
      40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
      40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
      40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
      40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
      40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_18_10_08
   };

   // How a directed row is checked: by the predictor, as no pixels, or as a blank cell.
   typedef enum logic [1:0] {
      CELL_PREDICT,
      CELL_NONE,
      CELL_BLANK
   } cell_kind_type;

   typedef struct packed {
      logic [7:0]    char_code;
      logic [15:0]   fore_color;
      logic [15:0]   back_color;
      cell_kind_type kind;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 17;
   localparam directed_row_type [0:DIRECTED_ROWS-1] DIRECTED_CELLS = {
      {8'd0,   16'hFFFF, 16'h0000, CELL_NONE},
      {8'd31,  16'hFFFF, 16'h0000, CELL_NONE},
      {8'd32,  16'hFFFF, 16'h0000, CELL_BLANK},
      {8'd32,  16'h0000, 16'hFFFF, CELL_BLANK},
      {8'd33,  16'hFFFF, 16'h0000, CELL_PREDICT},
      {8'd126, 16'h0000, 16'hFFFF, CELL_PREDICT},
      {8'd127, 16'hFFFF, 16'hFFFF, CELL_NONE},
      {8'd128, 16'hAAAA, 16'h5555, CELL_NONE},
      {8'd255, 16'h5555, 16'hAAAA, CELL_NONE},
      {8'd48,  16'hF800, 16'h001F, CELL_PREDICT},
      {8'd35,  16'h07E0, 16'hF81F, CELL_PREDICT},
      {8'd64,  16'hAAAA, 16'h5555, CELL_PREDICT},
      {8'd87,  16'h5555, 16'hAAAA, CELL_PREDICT},
      {8'd95,  16'hFFFF, 16'hFFFF, CELL_PREDICT},
      {8'd124, 16'h0000, 16'h0000, CELL_PREDICT},
      {8'd77,  16'h8000, 16'h0001, CELL_PREDICT},
      {8'd125, 16'h7FFF, 16'hFFFE, CELL_PREDICT}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   rsp_type pending_pixels [$];
   int      error_count = 0;

   glyph_to_pixel_renderer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #4 clock = ~clock;

   function automatic bit is_drawn(input logic [7:0] code);
      return code >= FIRST_CODE && int'(code - FIRST_CODE) < GLYPH_COUNT;
   endfunction

   // All 8 column bytes of a drawn code; right columns and unstored glyphs are blank.
   function automatic logic [CELL_SIZE-1:0][7:0] glyph_columns(input logic [7:0] code);
      logic [CELL_SIZE-1:0][7:0] cols;
      int                        glyph;
      cols = '0;
      glyph = int'(code - FIRST_CODE);
      if (glyph < STORED_GLYPHS) begin
         for (int c = 0; c < STORED_COLUMNS; c++)
            cols[c] = FONT_COLUMNS[glyph][c];
      end
      return cols;
   endfunction

   // Queue the 64 pixel transactions of one cell in raster order.
   function automatic void queue_cell_pixels(input logic [CELL_SIZE-1:0][7:0] cols,
                                             input logic [15:0] fore,
                                             input logic [15:0] back);
      rsp_type px;
      for (int r = 0; r < CELL_SIZE; r++) begin
         for (int c = 0; c < CELL_SIZE; c++) begin
            px.pixel_color  = cols[c][r] ? fore : back;
            px.pixel_row    = 3'(r);
            px.pixel_column = 3'(c);
            px.last_pixel   = (r == CELL_SIZE - 1) && (c == CELL_SIZE - 1);
            pending_pixels.push_back(px);
         end
      end
   endfunction

   function automatic void predict_char(input req_type item);
      if (is_drawn(item.char_code))
         queue_cell_pixels(glyph_columns(item.char_code), item.fore_color, item.back_color);
   endfunction

   // Returns at the edge that accepts the transaction; start is left high.
   // When may_idle is set, each offering cycle idles at random, so gaps also fall where busy is low.
   task automatic send_char(input req_type item, input bit may_idle);
      bit offered;
      req_item <= item;
      do begin
         offered = !(may_idle && $urandom_range(99) < 17);
         start <= offered;
         @(posedge clock);
      end while (!offered || busy);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_pixels.size() != 0);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual color %h row %0d col %0d last %0d",
                     $time, rsp_item.pixel_color, rsp_item.pixel_row,
                     rsp_item.pixel_column, rsp_item.last_pixel);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_color", want.pixel_color, rsp_item.pixel_color);
            check_field("pixel_row", want.pixel_row, rsp_item.pixel_row);
            check_field("pixel_column", want.pixel_column, rsp_item.pixel_column);
            check_field("last_pixel", want.last_pixel, rsp_item.last_pixel);
         end
      end
   end

   initial begin
      req_type          item;
      directed_row_type row;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_CELLS[i];
         item.char_code  = row.char_code;
         item.fore_color = row.fore_color;
         item.back_color = row.back_color;
         send_char(item, 1'b1);
         case (row.kind)
            CELL_PREDICT: predict_char(item);
            CELL_BLANK: queue_cell_pixels('0, item.fore_color, item.back_color);
            default: ;
         endcase
      end
      wait_for_drain();

      for (int i = 0; i < RANDOM_CHARS; i++) begin
         if (i == 300)
            wait_for_drain();
         if ($urandom_range(99) < 85)
            item.char_code = 8'($urandom_range(126, 32));
         else
            item.char_code = 8'($urandom_range(255, 0));
         item.fore_color = 16'($urandom);
         item.back_color = 16'($urandom);
         // hold start high across a long run of back-to-back characters
         send_char(item, !(i >= 150 && i < 250));
         predict_char(item);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("glyph_to_pixel_renderer_unit_tb OK");
      else
         $display("glyph_to_pixel_renderer_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout, %0d pixels still expected", $time, pending_pixels.size());
      $display("glyph_to_pixel_renderer_unit_tb NOT OK");
      $finish;
   end

endmodule
